FILE: rtl/core/bsa_pkg.sv
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types and codes of the banker's safe allocation block.
// ----------------------------------------------------------------------------
package bsa_pkg;

    // item field layout
    localparam int NUM_AMT   = 4;
    localparam int IN_AMT_W  = 8;
    localparam int PROC_W    = 3;
    localparam int CFG_ADR_W = 2;
    localparam int CFG_DAT_W = 4;

    // item function codes
    typedef enum logic [1:0] {
        FN_LOAD_MAX   = 2'd0,
        FN_LOAD_ALLOC = 2'd1,
        FN_SET_AVAIL  = 2'd2,
        FN_REQUEST    = 2'd3
    } t_func;

    // configuration register indexes
    typedef enum logic [CFG_ADR_W-1:0] {
        CFG_PROC_COUNT = 2'd0,
        CFG_RES_COUNT  = 2'd1,
        CFG_CHECK_MODE = 2'd2
    } t_cfg_idx;

    // result status codes
    typedef enum logic [2:0] {
        ST_GRANTED     = 3'd0,
        ST_LOADED      = 3'd1,
        ST_BAD_PROC    = 3'd2,
        ST_FINISHED    = 3'd3,
        ST_EXCEEDS     = 3'd4,
        ST_UNSAFE      = 3'd5,
        ST_ALLOC_OVER  = 3'd6,
        ST_AVAIL_UNSAFE = 3'd7
    } t_status;

    // command kinds after classification
    typedef enum logic [2:0] {
        K_LOAD_MAX,
        K_LOAD_ALLOC,
        K_SET_AVAIL,
        K_REQUEST,
        K_BAD_PROC
    } t_kind;

    // back end states
    typedef enum logic [2:0] {
        B_IDLE,
        B_EVAL,
        B_SCAN,
        B_VERDICT,
        B_GRANT,
        B_SINGLE,
        B_EMIT
    } t_bstate;

    // command passed from front to back
    typedef struct packed {
        t_kind                             kind;
        logic [PROC_W-1:0]                 process;
        logic [NUM_AMT-1:0][IN_AMT_W-1:0]  amount;
        logic [3:0]                        np;
        logic [2:0]                        nr;
        logic                              mode;
    } t_cmd;

    // queue status toward the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

FILE: rtl/core/bsa_front.sv
// ----------------------------------------------------------------------------
// bsa_front
// Holds configuration, accepts items and classifies them into commands.
// ----------------------------------------------------------------------------
module bsa_front #(
    parameter int MAX_PROCESSES = 8,
    parameter int MAX_RESOURCES = 4
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_cfg_we,
    input  logic [bsa_pkg::CFG_ADR_W-1:0]                   i_cfg_addr,
    input  logic [bsa_pkg::CFG_DAT_W-1:0]                   i_cfg_wdata,
    input  logic                                            i_valid,
    input  logic [1:0]                                      i_func,
    input  logic [bsa_pkg::PROC_W-1:0]                      i_process,
    input  logic [bsa_pkg::NUM_AMT-1:0][bsa_pkg::IN_AMT_W-1:0] i_amount,
    output logic                                            o_ready,
    input  bsa_pkg::t_qstat                                 i_qstat,
    output logic                                            o_push,
    output bsa_pkg::t_cmd                                   o_cmd
);
    localparam int PROC_LIM = (MAX_PROCESSES < 8) ? MAX_PROCESSES : 8;

    logic [3:0] r_proc_count;
    logic [2:0] r_res_count;
    logic       r_check_mode;
    logic [3:0] w_np;
    logic [2:0] w_nr;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_proc_count <= 4'd5;
            r_res_count  <= 3'd3;
            r_check_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (bsa_pkg::t_cfg_idx'(i_cfg_addr))
                bsa_pkg::CFG_PROC_COUNT: r_proc_count <= i_cfg_wdata;
                bsa_pkg::CFG_RES_COUNT:  r_res_count  <= i_cfg_wdata[2:0];
                bsa_pkg::CFG_CHECK_MODE: r_check_mode <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // clamp counts into the supported range
    always_comb begin
        if (r_proc_count == 4'd0)               w_np = 4'd1;
        else if (r_proc_count > 4'(PROC_LIM))   w_np = 4'(PROC_LIM);
        else                                    w_np = r_proc_count;
        if (r_res_count == 3'd0)                w_nr = 3'd1;
        else if (r_res_count > 3'(MAX_RESOURCES)) w_nr = 3'(MAX_RESOURCES);
        else                                    w_nr = r_res_count;
    end

    // classify the item
    always_comb begin
        o_cmd.process = i_process;
        o_cmd.amount  = i_amount;
        o_cmd.np      = w_np;
        o_cmd.nr      = w_nr;
        o_cmd.mode    = r_check_mode;
        if (bsa_pkg::t_func'(i_func) == bsa_pkg::FN_SET_AVAIL) begin
            o_cmd.kind = bsa_pkg::K_SET_AVAIL;
        end else if (4'(i_process) >= w_np) begin
            o_cmd.kind = bsa_pkg::K_BAD_PROC;
        end else begin
            case (bsa_pkg::t_func'(i_func))
                bsa_pkg::FN_LOAD_MAX:   o_cmd.kind = bsa_pkg::K_LOAD_MAX;
                bsa_pkg::FN_LOAD_ALLOC: o_cmd.kind = bsa_pkg::K_LOAD_ALLOC;
                default:                o_cmd.kind = bsa_pkg::K_REQUEST;
            endcase
        end
    end

    assign o_ready = !i_qstat.full;
    assign o_push  = i_valid && !i_qstat.full;

endmodule

FILE: rtl/core/bsa_queue.sv
// ----------------------------------------------------------------------------
// bsa_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module bsa_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bsa_pkg::t_cmd   i_cmd,
    input  logic            i_pop,
    output bsa_pkg::t_cmd   o_cmd,
    output bsa_pkg::t_qstat o_qstat
);
    bsa_pkg::t_cmd r_mem [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_cnt;
    logic          w_push;
    logic          w_pop;

    assign w_push = i_push && (r_cnt != 2'd2);
    assign w_pop  = i_pop && (r_cnt != 2'd0);

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wr <= !r_wr;
            if (w_pop)  r_rd <= !r_rd;
            if (w_push && !w_pop)      r_cnt <= r_cnt + 2'd1;
            else if (w_pop && !w_push) r_cnt <= r_cnt - 2'd1;
        end
    end

    assign o_cmd         = r_mem[r_rd];
    assign o_qstat.full  = (r_cnt == 2'd2);
    assign o_qstat.empty = (r_cnt == 2'd0);

endmodule

FILE: rtl/core/bsa_back.sv
// ----------------------------------------------------------------------------
// bsa_back
// Executes commands: table loads, request checks, the safety scan, grants
// and releases, and drives the result register.
// ----------------------------------------------------------------------------
module bsa_back #(
    parameter int MAX_PROCESSES = 8,
    parameter int MAX_RESOURCES = 4,
    parameter int AMOUNT_BITS   = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bsa_pkg::t_qstat             i_qstat,
    input  bsa_pkg::t_cmd               i_cmd,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output bsa_pkg::t_status            o_status,
    output logic [bsa_pkg::PROC_W-1:0]  o_seq,
    output logic                        o_rel,
    output logic                        o_last
);
    localparam int PROC_LIM = (MAX_PROCESSES < 8) ? MAX_PROCESSES : 8;
    localparam int PW       = $clog2(PROC_LIM);
    localparam int TBL_D    = 2 ** PW;
    localparam int NR       = MAX_RESOURCES;
    localparam int AB       = AMOUNT_BITS;
    localparam int WW       = AB + 4;
    localparam logic [AB-1:0] AMT_MAX = {AB{1'b1}};

    bsa_pkg::t_bstate r_state, n_state;
    bsa_pkg::t_cmd    r_cmd;
    bsa_pkg::t_status r_status;
    logic             r_rel;
    logic             r_tent;

    logic [AB-1:0] r_max   [TBL_D][NR];
    logic [AB-1:0] r_alloc [TBL_D][NR];
    logic [AB-1:0] r_avail [NR];
    logic [WW-1:0] r_work  [NR];
    logic [TBL_D-1:0] r_fin;
    logic [TBL_D-1:0] r_mark;
    logic [PW-1:0] r_seq [TBL_D];
    logic [3:0]    r_cnt;
    logic [3:0]    r_pass;
    logic [PW-1:0] r_idx;
    logic [PW-1:0] r_emit;

    logic                  r_out_valid;
    bsa_pkg::t_status      r_out_status;
    logic [bsa_pkg::PROC_W-1:0] r_out_seq;
    logic                  r_out_rel;
    logic                  r_out_last;

    logic [PW-1:0] w_p;
    logic [PW-1:0] w_row;
    logic [AB-1:0] w_amt     [NR];
    logic [NR-1:0] w_en;
    logic [AB:0]   w_alloc_t [NR];
    logic [AB-1:0] w_need    [NR];
    logic [AB:0]   w_sum     [NR];
    logic [AB-1:0] w_sub     [NR];
    logic [AB:0]   w_rls     [NR];
    logic          w_over_max;
    logic          w_over_req;
    logic          w_fits;
    logic          w_complete;
    logic          w_hit;
    logic          w_scan_done;
    logic          w_safe;
    logic          w_out_free;
    logic          w_emit_last;

    assign w_p   = r_cmd.process[PW-1:0];
    assign w_row = (r_state == bsa_pkg::B_SCAN) ? r_idx : w_p;

    // row arithmetic on the selected table row
    always_comb begin
        w_over_max = 1'b0;
        w_over_req = 1'b0;
        w_fits     = 1'b1;
        w_complete = 1'b1;
        for (int j = 0; j < NR; j++) begin
            w_amt[j] = AB'(r_cmd.amount[j]);
            w_en[j]  = (3'(j) < r_cmd.nr);
            w_alloc_t[j] = {1'b0, r_alloc[w_row][j]};
            if (r_tent && (w_row == w_p) && w_en[j]) begin
                w_alloc_t[j] = w_alloc_t[j] + {1'b0, w_amt[j]};
            end
            w_need[j] = ({1'b0, r_max[w_row][j]} >= w_alloc_t[j]) ?
                        AB'({1'b0, r_max[w_row][j]} - w_alloc_t[j]) : '0;
            w_sum[j] = {1'b0, r_alloc[w_row][j]} + {1'b0, w_amt[j]};
            w_sub[j] = r_avail[j] - w_amt[j];
            w_rls[j] = {1'b0, w_sub[j]} + {1'b0, r_max[w_row][j]};
            if (w_en[j]) begin
                if (w_amt[j] > r_max[w_row][j]) w_over_max = 1'b1;
                if (w_amt[j] > r_avail[j] || w_amt[j] > w_need[j]) w_over_req = 1'b1;
                if (WW'(w_need[j]) > r_work[j]) w_fits = 1'b0;
                if ({1'b0, r_max[w_row][j]} != w_sum[j]) w_complete = 1'b0;
            end
        end
    end

    // scan progress and verdict
    assign w_hit       = !r_mark[r_idx] && w_fits;
    assign w_scan_done = ((r_pass == r_cmd.np) && (4'(r_idx) == r_cmd.np - 4'd1)) ||
                         (w_hit && (r_cnt + 4'd1 == r_cmd.np));
    assign w_safe      = (r_cnt == r_cmd.np);
    assign w_out_free  = !r_out_valid || i_ready;
    assign w_emit_last = (4'(r_emit) == r_cnt - 4'd1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bsa_pkg::B_IDLE: begin
                if (!i_qstat.empty) n_state = bsa_pkg::B_EVAL;
            end
            bsa_pkg::B_EVAL: begin
                case (r_cmd.kind)
                    bsa_pkg::K_SET_AVAIL: n_state = bsa_pkg::B_SCAN;
                    bsa_pkg::K_REQUEST: begin
                        if (r_fin[w_p] || w_over_req) n_state = bsa_pkg::B_SINGLE;
                        else if (r_cmd.mode)          n_state = bsa_pkg::B_GRANT;
                        else                          n_state = bsa_pkg::B_SCAN;
                    end
                    default: n_state = bsa_pkg::B_SINGLE;
                endcase
            end
            bsa_pkg::B_SCAN: begin
                if (w_scan_done) n_state = bsa_pkg::B_VERDICT;
            end
            bsa_pkg::B_VERDICT: begin
                if (!w_safe)                              n_state = bsa_pkg::B_SINGLE;
                else if (r_cmd.kind == bsa_pkg::K_SET_AVAIL) n_state = bsa_pkg::B_EMIT;
                else                                      n_state = bsa_pkg::B_GRANT;
            end
            bsa_pkg::B_GRANT: begin
                n_state = r_cmd.mode ? bsa_pkg::B_SINGLE : bsa_pkg::B_EMIT;
            end
            bsa_pkg::B_SINGLE: begin
                if (w_out_free) n_state = bsa_pkg::B_IDLE;
            end
            bsa_pkg::B_EMIT: begin
                if (w_out_free && w_emit_last) n_state = bsa_pkg::B_IDLE;
            end
            default: n_state = bsa_pkg::B_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop = (r_state == bsa_pkg::B_IDLE) && !i_qstat.empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= bsa_pkg::B_IDLE;
        else          r_state <= n_state;
    end

    // command register
    always_ff @(posedge i_clk) begin
        if (o_pop) r_cmd <= i_cmd;
    end

    // tables and scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TBL_D; i++) begin
                for (int j = 0; j < NR; j++) begin
                    r_max[i][j]   <= '0;
                    r_alloc[i][j] <= '0;
                end
            end
            for (int j = 0; j < NR; j++) begin
                r_avail[j] <= '0;
                r_work[j]  <= '0;
            end
            r_fin    <= '0;
            r_mark   <= '0;
            r_cnt    <= '0;
            r_pass   <= '0;
            r_idx    <= '0;
            r_emit   <= '0;
            r_tent   <= 1'b0;
            r_rel    <= 1'b0;
            r_status <= bsa_pkg::ST_GRANTED;
        end else begin
            case (r_state)
                bsa_pkg::B_EVAL: begin
                    r_rel  <= 1'b0;
                    r_mark <= '0;
                    r_cnt  <= '0;
                    r_pass <= '0;
                    r_idx  <= '0;
                    r_tent <= 1'b0;
                    case (r_cmd.kind)
                        bsa_pkg::K_BAD_PROC: r_status <= bsa_pkg::ST_BAD_PROC;
                        bsa_pkg::K_LOAD_MAX: begin
                            for (int j = 0; j < NR; j++) r_max[w_p][j] <= w_amt[j];
                            r_fin[w_p] <= 1'b0;
                            r_status   <= bsa_pkg::ST_LOADED;
                        end
                        bsa_pkg::K_LOAD_ALLOC: begin
                            if (w_over_max) begin
                                r_status <= bsa_pkg::ST_ALLOC_OVER;
                            end else begin
                                for (int j = 0; j < NR; j++) r_alloc[w_p][j] <= w_amt[j];
                                r_fin[w_p] <= 1'b0;
                                r_status   <= bsa_pkg::ST_LOADED;
                            end
                        end
                        bsa_pkg::K_SET_AVAIL: begin
                            for (int j = 0; j < NR; j++) r_work[j] <= WW'(w_amt[j]);
                        end
                        default: begin
                            if (r_fin[w_p]) begin
                                r_status <= bsa_pkg::ST_FINISHED;
                            end else if (w_over_req) begin
                                r_status <= bsa_pkg::ST_EXCEEDS;
                            end else begin
                                r_status <= bsa_pkg::ST_GRANTED;
                                r_tent   <= !r_cmd.mode;
                                for (int j = 0; j < NR; j++) begin
                                    r_work[j] <= w_en[j] ? WW'(w_sub[j]) : WW'(r_avail[j]);
                                end
                            end
                        end
                    endcase
                end
                bsa_pkg::B_SCAN: begin
                    // one process per cycle, passes in index order
                    if (w_hit) begin
                        r_mark[r_idx]           <= 1'b1;
                        r_seq[r_cnt[PW-1:0]]    <= r_idx;
                        r_cnt                   <= r_cnt + 4'd1;
                        for (int j = 0; j < NR; j++) begin
                            if (w_en[j]) r_work[j] <= r_work[j] + WW'(w_alloc_t[j]);
                        end
                    end
                    if (4'(r_idx) == r_cmd.np - 4'd1) begin
                        r_idx  <= '0;
                        r_pass <= r_pass + 4'd1;
                    end else begin
                        r_idx <= r_idx + PW'(1);
                    end
                end
                bsa_pkg::B_VERDICT: begin
                    r_tent <= 1'b0;
                    r_emit <= '0;
                    if (r_cmd.kind == bsa_pkg::K_SET_AVAIL) begin
                        if (w_safe) begin
                            for (int j = 0; j < NR; j++) r_avail[j] <= w_amt[j];
                            r_status <= bsa_pkg::ST_LOADED;
                        end else begin
                            r_status <= bsa_pkg::ST_AVAIL_UNSAFE;
                        end
                    end else begin
                        r_status <= w_safe ? bsa_pkg::ST_GRANTED : bsa_pkg::ST_UNSAFE;
                    end
                end
                bsa_pkg::B_GRANT: begin
                    r_rel <= w_complete;
                    if (w_complete) begin
                        // process completes: free its claim and clear its rows
                        r_fin[w_p] <= 1'b1;
                        for (int j = 0; j < NR; j++) begin
                            r_max[w_p][j]   <= '0;
                            r_alloc[w_p][j] <= '0;
                            if (w_en[j]) begin
                                r_avail[j] <= (w_rls[j] > {1'b0, AMT_MAX}) ?
                                              AMT_MAX : w_rls[j][AB-1:0];
                            end
                        end
                    end else begin
                        for (int j = 0; j < NR; j++) begin
                            if (w_en[j]) begin
                                r_alloc[w_p][j] <= w_sum[j][AB-1:0];
                                r_avail[j]      <= w_sub[j];
                            end
                        end
                    end
                end
                bsa_pkg::B_EMIT: begin
                    if (w_out_free) r_emit <= r_emit + PW'(1);
                end
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free && ((r_state == bsa_pkg::B_SINGLE) ||
                                     (r_state == bsa_pkg::B_EMIT))) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && (r_state == bsa_pkg::B_SINGLE)) begin
            r_out_status <= r_status;
            r_out_seq    <= '0;
            r_out_rel    <= r_rel;
            r_out_last   <= 1'b1;
        end else if (w_out_free && (r_state == bsa_pkg::B_EMIT)) begin
            r_out_status <= r_status;
            r_out_seq    <= bsa_pkg::PROC_W'(r_seq[r_emit]);
            r_out_rel    <= r_rel;
            r_out_last   <= w_emit_last;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_out_status;
    assign o_seq    = r_out_seq;
    assign o_rel    = r_out_rel;
    assign o_last   = r_out_last;

endmodule

FILE: rtl/core/bankers_safe_allocation.sv
// Flow: loads and rejected items pass from the command queue through the command
// register, evaluation and the result register to give their single result; a
// safety check scans one process per cycle in passes in index order, then emits
// one result per cycle per sequence entry while the output is ready.
// Ordering: one item at a time in the back end; a two-entry command queue lets
// the input side take items while the back works.
// ----------------------------------------------------------------------------
// bankers_safe_allocation
// Banker's algorithm allocator with safety-checked grants and releases.
// Reset: synchronous, active low; clears all tables, flags and the result valid.
// ----------------------------------------------------------------------------
module bankers_safe_allocation #(
    parameter int MAX_PROCESSES = 8,
    parameter int MAX_RESOURCES = 4,
    parameter int AMOUNT_BITS   = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bsa_pkg::CFG_ADR_W-1:0]     i_cfg_addr,
    input  logic [bsa_pkg::CFG_DAT_W-1:0]     i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // process[2:0], amount_0[10:3], amount_1[18:11], amount_2[26:19],
    // amount_3[34:27], zero fill[39:35]
    input  logic [39:0]                       s_axis_tdata,
    // func[1:0]
    input  logic [1:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // seq_process[2:0], released[3], zero fill[7:4]
    output logic [7:0]                        m_axis_tdata,
    // status[2:0]
    output logic [2:0]                        m_axis_tuser,
    output logic                              m_axis_tlast
);
    logic [bsa_pkg::NUM_AMT-1:0][bsa_pkg::IN_AMT_W-1:0] w_amount;
    bsa_pkg::t_cmd    w_push_cmd;
    bsa_pkg::t_cmd    w_head_cmd;
    bsa_pkg::t_qstat  w_qstat;
    bsa_pkg::t_status w_status;
    logic             w_push;
    logic             w_pop;
    logic [bsa_pkg::PROC_W-1:0] w_seq;
    logic             w_rel;

    // unpack amounts
    always_comb begin
        for (int j = 0; j < bsa_pkg::NUM_AMT; j++) begin
            w_amount[j] = s_axis_tdata[3 + j*8 +: 8];
        end
    end

    bsa_front #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .MAX_RESOURCES (MAX_RESOURCES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .i_func      (s_axis_tuser),
        .i_process   (s_axis_tdata[2:0]),
        .i_amount    (w_amount),
        .o_ready     (s_axis_tready),
        .i_qstat     (w_qstat),
        .o_push      (w_push),
        .o_cmd       (w_push_cmd)
    );

    bsa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_qstat (w_qstat)
    );

    bsa_back #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .MAX_RESOURCES (MAX_RESOURCES),
        .AMOUNT_BITS   (AMOUNT_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qstat  (w_qstat),
        .i_cmd    (w_head_cmd),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_status (w_status),
        .o_seq    (w_seq),
        .o_rel    (w_rel),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, w_rel, w_seq};
    assign m_axis_tuser = w_status;

    // only sequence results come in runs longer than one
    a_multi_is_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |->
        (m_axis_tuser == bsa_pkg::ST_GRANTED || m_axis_tuser == bsa_pkg::ST_LOADED))
        else $error("non-sequence result without last");

    // a release only comes with a grant
    a_rel_granted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[3]) |-> (m_axis_tuser == bsa_pkg::ST_GRANTED))
        else $error("release flagged on a non-grant result");

    // rejections carry no sequence entry
    a_reject_seq_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != bsa_pkg::ST_GRANTED &&
         m_axis_tuser != bsa_pkg::ST_LOADED) |-> (m_axis_tdata[2:0] == 3'd0))
        else $error("rejection result with a sequence entry");

endmodule
